@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the estimator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define BCSE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define BCSE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCSE_ASSERT(label, clk, rst_n, prop, msg)
`define BCSE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ rtl/core/bcse_pkg.sv @@
// shared types and constants of the charge state estimator
package bcse_pkg;

    localparam int CURVE_POINTS = 8;
    localparam int FULL_SCALE   = 10000;
    localparam int PCT_MAX      = 100;
    localparam int MIN_SPAN     = 10;
    localparam int BOOT_LO      = 1000;
    localparam int BOOT_HI      = 9000;
    localparam int CRV_FALLBACK = 5000;
    localparam int DIR_THRESH   = 10;

    localparam int IN_W      = 128;
    localparam int OUT_W     = 24;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 32;
    localparam int PCT_W     = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EMPTY_MV   = 3'd0,
        REG_FULL_MV    = 3'd1,
        REG_MARGIN_MV  = 3'd2,
        REG_HOLD_MS    = 3'd3,
        REG_MAX_STEP   = 3'd4,
        REG_CURVE_MV_L = 3'd5,
        REG_CURVE_MV_H = 3'd6,
        REG_CURVE_PCT  = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_CRV_DIRECT,
        CMD_CRV_LOAD,
        CMD_CRV_FIN,
        CMD_UPDATE,
        CMD_SET_FULL,
        CMD_FULL_FIN,
        CMD_SET_EMPTY,
        CMD_EMPTY_FIN,
        CMD_PCT_LOAD,
        CMD_PCT_FIN,
        CMD_PCT_CURVE,
        CMD_OUT_LOAD
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
        logic      div_start;
    } dp_cmd_t;

    typedef struct packed {
        logic counter_seen;
        logic crv_div;
        logic full_ev;
        logic empty_ev;
        logic full_prov;
        logic empty_prov;
        logic span_use;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/core/bcse_div.sv @@
// iterative rounding divider, one quotient bit per cycle
`include "assert_macros.svh"

module bcse_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [bcse_pkg::NUM_W-1:0]   num,
    input  logic        [bcse_pkg::DEN_W-1:0]   den,
    output logic                                done,
    output logic        [bcse_pkg::NUM_W-1:0]   q_mag,
    output logic                                q_neg
);

    localparam int NW = bcse_pkg::NUM_W;
    localparam int DW = bcse_pkg::DEN_W;

    logic                 rnd_reg, run_reg, done_reg, neg_reg;
    logic [$clog2(NW)-1:0] cnt_reg;
    logic [NW-1:0]        mag_reg;
    logic [DW-1:0]        den_reg, rem_reg;
    logic [DW:0]          rem_sh;
    logic                 ge;

    assign rem_sh = {rem_reg, mag_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_reg  <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rnd_reg <= 1'b1;
            end else if (rnd_reg) begin
                rnd_reg <= 1'b0;
                run_reg <= 1'b1;
            end else if (run_reg && cnt_reg == '0) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[NW-1];
            mag_reg <= num[NW-1] ? NW'(-num) : NW'(num);
            den_reg <= den;
        end else if (rnd_reg) begin
            // bias by half the divisor for round to nearest
            mag_reg <= mag_reg + NW'(den_reg >> 1);
            rem_reg <= '0;
            cnt_reg <= ($clog2(NW))'(NW - 1);
        end else if (run_reg) begin
            mag_reg <= {mag_reg[NW-2:0], ge};
            rem_reg <= ge ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done  = done_reg;
    assign q_mag = mag_reg;
    assign q_neg = neg_reg;

    `BCSE_ASSERT(a_start_idle, aclk, aresetn, start |-> !run_reg && !rnd_reg, "divider restarted while busy")
    `BCSE_ASSERT(a_done_after_run, aclk, aresetn, done_reg |-> $past(run_reg), "done without iteration")
    `BCSE_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !run_reg && !rnd_reg && !done_reg, "divider busy after reset")

endmodule

@@ rtl/core/bcse_dp.sv @@
// datapath: configuration, estimator state, curve lookup, divider and output register
`include "assert_macros.svh"

module bcse_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [bcse_pkg::IN_W-1:0]            s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bcse_pkg::OUT_W-1:0]           m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [bcse_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcse_pkg::CFG_W-1:0]           cfg_data,
    input  bcse_pkg::dp_cmd_t                    cmd,
    output bcse_pkg::dp_status_t                 status
);

    localparam int NP   = bcse_pkg::CURVE_POINTS;
    localparam int NW   = bcse_pkg::NUM_W;
    localparam int PW   = bcse_pkg::PCT_W;
    localparam logic signed [NW-1:0] SCALE_S = NW'(bcse_pkg::FULL_SCALE);
    localparam logic signed [15:0]   DIR_S   = 16'(bcse_pkg::DIR_THRESH);

    typedef struct packed {
        logic [14:0] low_mv;
        logic [14:0] full_mv;
        logic [9:0]  margin;
        logic [31:0] hold;
        logic [30:0] step;
        logic [63:0] mv_lo;
        logic [63:0] mv_hi;
        logic [63:0] pct_pts;
    } cfg_t;

    typedef struct packed {
        logic [31:0]   rc;
        logic [31:0]   last;
        logic [31:0]   fanchor;
        logic [31:0]   eanchor;
        logic [31:0]   bcharge;
        logic [31:0]   fhs;
        logic [31:0]   ehs;
        logic [31:0]   span;
        logic [PW-1:0] bfrac;
        logic seen, chg_seen, dis_seen, flat, elat, fknown, eknown, span_valid, span_prov;
    } est_t;

    typedef struct packed {
        logic [31:0]   cc;
        logic [15:0]   cur;
        logic [14:0]   avg;
        logic [14:0]   vmax;
        logic [14:0]   vmin;
        logic          ov, uv;
        logic [31:0]   now;
        logic [PW-1:0] crv_base, crv_pct, pct;
        logic          fev, eev;
        logic [NW-1:0] div_num;
        logic [31:0]   div_den;
    } work_t;

    typedef struct packed {
        logic [PW-1:0] pct;
        logic known, prov, fev, eev;
    } out_t;

    localparam cfg_t CFG_RESET = '{
        low_mv: 15'd3000, full_mv: 15'd4200, margin: 10'd20, hold: 32'd60000,
        step: 31'd100000, mv_lo: '0, mv_hi: '0, pct_pts: '0};

    cfg_t  cfg_reg, cfg_next;
    est_t  est_reg, est_next;
    work_t wk_reg, wk_next;
    out_t  out_reg, out_next;
    logic  m_valid_reg, m_valid_next;

    logic          div_done, q_neg;
    logic [NW-1:0] q_mag;
    logic signed [NW:0] q_s;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // ---------------- curve lookup
    logic [15:0]   mv_pt  [NP];
    logic [PW-1:0] pct_pt [NP];
    logic [14:0]   avg_cl, b;
    logic          le_first, ge_last, found;
    logic [15:0]   seg_lo, seg_hi, crv_den;
    logic [PW-1:0] seg_plo, seg_phi, crv_direct;
    logic signed [16:0] crv_off;
    logic signed [14:0] crv_dp;
    logic signed [31:0] crv_prod;
    logic signed [15:0] crv_sum;
    logic          crv_div;

    always_comb begin
        logic [7:0] p;
        for (int i = 0; i < NP; i++) begin
            mv_pt[i] = (i < 4) ? cfg_reg.mv_lo[16*(i & 3) +: 16] : cfg_reg.mv_hi[16*(i & 3) +: 16];
            p = cfg_reg.pct_pts[8*i +: 8];
            pct_pt[i] = (p > 8'(bcse_pkg::PCT_MAX)) ? PW'(bcse_pkg::FULL_SCALE)
                                                     : PW'(PW'(p) * PW'(bcse_pkg::PCT_MAX));
        end
    end

    assign avg_cl   = (wk_reg.avg > cfg_reg.full_mv) ? cfg_reg.full_mv : wk_reg.avg;
    assign b        = (avg_cl < cfg_reg.low_mv) ? cfg_reg.low_mv : avg_cl;
    assign le_first = {1'b0, b} <= mv_pt[0];
    assign ge_last  = {1'b0, b} >= mv_pt[NP-1];

    // first segment that holds the clamped voltage
    always_comb begin
        found   = 1'b0;
        seg_lo  = '0;
        seg_hi  = '0;
        seg_plo = '0;
        seg_phi = '0;
        for (int i = 0; i < NP - 1; i++) begin
            if (!found && {1'b0, b} >= mv_pt[i] && {1'b0, b} <= mv_pt[i+1]) begin
                found   = 1'b1;
                seg_lo  = mv_pt[i];
                seg_hi  = mv_pt[i+1];
                seg_plo = pct_pt[i];
                seg_phi = pct_pt[i+1];
            end
        end
    end

    assign crv_den  = seg_hi - seg_lo;
    assign crv_div  = !le_first && !ge_last && found && (crv_den != '0);
    assign crv_off  = $signed({2'b00, b}) - $signed({1'b0, seg_lo});
    assign crv_dp   = $signed({1'b0, seg_phi}) - $signed({1'b0, seg_plo});
    assign crv_prod = crv_off * crv_dp;
    assign crv_sum  = $signed({2'b00, wk_reg.crv_base}) + $signed(q_s[15:0]);

    always_comb begin
        if (le_first) begin
            crv_direct = pct_pt[0];
        end else if (ge_last) begin
            crv_direct = pct_pt[NP-1];
        end else if (found) begin
            crv_direct = seg_plo;
        end else begin
            crv_direct = PW'(bcse_pkg::CRV_FALLBACK);
        end
    end

    // ---------------- sample update
    logic signed [32:0] delta, dmag;
    logic signed [33:0] rc_sum;
    logic        step_ok, chg, dis, rest, chg_new, dis_new;
    logic        full_v, empty_v, full_hit, empty_hit;
    logic [31:0] fhs_new, ehs_new;
    logic signed [16:0] full_thr;
    logic [15:0] empty_thr;

    assign delta   = $signed({wk_reg.cc[31], wk_reg.cc}) - $signed({est_reg.last[31], est_reg.last});
    assign dmag    = delta[32] ? -delta : delta;
    assign step_ok = dmag < $signed({2'b00, cfg_reg.step});
    assign rc_sum  = $signed({{2{est_reg.rc[31]}}, est_reg.rc}) + $signed({delta[32], delta});

    assign chg     = $signed(wk_reg.cur) < -DIR_S;
    assign dis     = $signed(wk_reg.cur) > DIR_S;
    assign rest    = $signed(wk_reg.cur) > -DIR_S
                  && $signed(wk_reg.cur) < DIR_S;
    assign chg_new = est_reg.chg_seen || chg;
    assign dis_new = est_reg.dis_seen || (!chg && dis);

    assign full_thr  = $signed({2'b00, cfg_reg.full_mv}) - $signed({7'b0, cfg_reg.margin});
    assign full_v    = $signed({2'b00, wk_reg.vmax}) >= full_thr;
    assign empty_thr = {1'b0, cfg_reg.low_mv} + {6'b0, cfg_reg.margin};
    assign empty_v   = {1'b0, wk_reg.vmin} <= empty_thr;

    assign fhs_new = !full_v ? '0 : (est_reg.fhs == '0 ? wk_reg.now : est_reg.fhs);
    assign ehs_new = !empty_v ? '0 : (est_reg.ehs == '0 ? wk_reg.now : est_reg.ehs);

    assign full_hit  = wk_reg.ov || (full_v && chg_new && rest && fhs_new != '0
                       && (wk_reg.now - fhs_new) >= cfg_reg.hold);
    assign empty_hit = wk_reg.uv || (empty_v && dis_new && ehs_new != '0
                       && (wk_reg.now - ehs_new) >= cfg_reg.hold);

    // ---------------- span and percent arithmetic
    logic        boot_ok, span_ok;
    logic signed [32:0] mul_a, meas_f, meas_e;
    logic signed [NW-1:0] mul_p;
    logic [31:0] span_sat;

    assign boot_ok = est_reg.bfrac >= PW'(bcse_pkg::BOOT_LO) && est_reg.bfrac <= PW'(bcse_pkg::BOOT_HI);
    assign meas_f  = $signed({est_reg.rc[31], est_reg.rc})
                   - $signed({est_reg.eanchor[31], est_reg.eanchor});
    assign meas_e  = $signed({est_reg.fanchor[31], est_reg.fanchor})
                   - $signed({est_reg.rc[31], est_reg.rc});

    always_comb begin
        case (cmd.code)
            bcse_pkg::CMD_SET_FULL:  mul_a = $signed({est_reg.rc[31], est_reg.rc})
                                           - $signed({est_reg.bcharge[31], est_reg.bcharge});
            bcse_pkg::CMD_SET_EMPTY: mul_a = $signed({est_reg.bcharge[31], est_reg.bcharge})
                                           - $signed({est_reg.rc[31], est_reg.rc});
            default:                 mul_a = meas_f;
        endcase
    end

    assign mul_p    = $signed({{(NW-33){mul_a[32]}}, mul_a}) * SCALE_S;
    assign q_s      = q_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    assign span_ok  = !q_neg && q_mag > NW'(bcse_pkg::MIN_SPAN);
    assign span_sat = (|q_mag[NW-1:32]) ? 32'hFFFF_FFFF : q_mag[31:0];

    // ---------------- command decode
    always_comb begin
        cfg_next     = cfg_reg;
        est_next     = est_reg;
        wk_next      = wk_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_tready;

        if (cfg_wr_en) begin
            unique case (bcse_pkg::cfg_reg_t'(cfg_index))
                bcse_pkg::REG_EMPTY_MV:   cfg_next.low_mv   = cfg_data[14:0];
                bcse_pkg::REG_FULL_MV:    cfg_next.full_mv  = cfg_data[14:0];
                bcse_pkg::REG_MARGIN_MV:  cfg_next.margin   = cfg_data[9:0];
                bcse_pkg::REG_HOLD_MS:    cfg_next.hold     = cfg_data[31:0];
                bcse_pkg::REG_MAX_STEP:   cfg_next.step     = cfg_data[30:0];
                bcse_pkg::REG_CURVE_MV_L: cfg_next.mv_lo    = cfg_data;
                bcse_pkg::REG_CURVE_MV_H: cfg_next.mv_hi    = cfg_data;
                bcse_pkg::REG_CURVE_PCT:  cfg_next.pct_pts  = cfg_data;
            endcase
        end

        unique case (cmd.code)
            bcse_pkg::CMD_CAPTURE: begin
                wk_next.cc   = s_tdata[31:0];
                wk_next.cur  = s_tdata[47:32];
                wk_next.avg  = s_tdata[62:48];
                wk_next.vmax = s_tdata[77:63];
                wk_next.vmin = s_tdata[92:78];
                wk_next.ov   = s_tdata[93];
                wk_next.uv   = s_tdata[94];
                wk_next.now  = s_tdata[126:95];
            end
            bcse_pkg::CMD_CRV_DIRECT: wk_next.crv_pct = crv_direct;
            bcse_pkg::CMD_CRV_LOAD: begin
                wk_next.crv_base = seg_plo;
                wk_next.div_num  = {{(NW-32){crv_prod[31]}}, crv_prod};
                wk_next.div_den  = {16'b0, crv_den};
            end
            bcse_pkg::CMD_CRV_FIN: wk_next.crv_pct = crv_sum[PW-1:0];
            bcse_pkg::CMD_UPDATE: begin
                if (!est_reg.seen) begin
                    est_next.bfrac   = wk_reg.crv_pct;
                    est_next.bcharge = est_reg.rc;
                end else if (step_ok) begin
                    est_next.rc = sat32(rc_sum);
                end
                est_next.last     = wk_reg.cc;
                est_next.seen     = 1'b1;
                est_next.chg_seen = chg_new;
                est_next.dis_seen = dis_new;
                est_next.fhs      = fhs_new;
                est_next.ehs      = ehs_new;
                est_next.flat     = full_hit;
                est_next.elat     = empty_hit;
                wk_next.fev       = full_hit && !est_reg.flat;
                wk_next.eev       = empty_hit && !est_reg.elat;
            end
            bcse_pkg::CMD_SET_FULL: begin
                est_next.fknown  = 1'b1;
                est_next.fanchor = est_reg.rc;
                est_next.fhs     = '0;
                if (est_reg.eknown && meas_f > 33'sd10) begin
                    est_next.span       = meas_f[31:0];
                    est_next.span_valid = 1'b1;
                    est_next.span_prov  = 1'b0;
                end
                wk_next.div_num = mul_p;
                wk_next.div_den = 32'(bcse_pkg::FULL_SCALE) - 32'(est_reg.bfrac);
            end
            bcse_pkg::CMD_FULL_FIN: begin
                if (span_ok) begin
                    est_next.span       = span_sat;
                    est_next.eanchor    = sat32($signed({{2{est_reg.fanchor[31]}}, est_reg.fanchor})
                                              - $signed({2'b00, span_sat}));
                    est_next.span_valid = 1'b1;
                    est_next.span_prov  = 1'b1;
                end
            end
            bcse_pkg::CMD_SET_EMPTY: begin
                est_next.eknown  = 1'b1;
                est_next.eanchor = est_reg.rc;
                est_next.ehs     = '0;
                if (est_reg.fknown && meas_e > 33'sd10) begin
                    est_next.span       = meas_e[31:0];
                    est_next.span_valid = 1'b1;
                    est_next.span_prov  = 1'b0;
                end
                wk_next.div_num = mul_p;
                wk_next.div_den = 32'(est_reg.bfrac);
            end
            bcse_pkg::CMD_EMPTY_FIN: begin
                if (span_ok) begin
                    est_next.span       = span_sat;
                    est_next.fanchor    = sat32($signed({{2{est_reg.eanchor[31]}}, est_reg.eanchor})
                                              + $signed({2'b00, span_sat}));
                    est_next.span_valid = 1'b1;
                    est_next.span_prov  = 1'b1;
                end
            end
            bcse_pkg::CMD_PCT_LOAD: begin
                wk_next.div_num = mul_p;
                wk_next.div_den = est_reg.span;
            end
            bcse_pkg::CMD_PCT_FIN: begin
                if (q_neg) begin
                    wk_next.pct = '0;
                end else if (q_mag > NW'(bcse_pkg::FULL_SCALE)) begin
                    wk_next.pct = PW'(bcse_pkg::FULL_SCALE);
                end else begin
                    wk_next.pct = q_mag[PW-1:0];
                end
            end
            bcse_pkg::CMD_PCT_CURVE: wk_next.pct = wk_reg.crv_pct;
            bcse_pkg::CMD_OUT_LOAD: begin
                out_next.pct   = wk_reg.pct;
                out_next.known = est_reg.span_valid;
                out_next.prov  = est_reg.span_prov;
                out_next.fev   = wk_reg.fev;
                out_next.eev   = wk_reg.eev;
                m_valid_next   = 1'b1;
            end
            bcse_pkg::CMD_NONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= CFG_RESET;
            est_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            est_reg     <= est_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wk_reg  <= wk_next;
        out_reg <= out_next;
    end

    bcse_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (wk_reg.div_num),
        .den     (wk_reg.div_den),
        .done    (div_done),
        .q_mag   (q_mag),
        .q_neg   (q_neg)
    );

    assign status.counter_seen = est_reg.seen;
    assign status.crv_div      = crv_div;
    assign status.full_ev      = wk_reg.fev;
    assign status.empty_ev     = wk_reg.eev;
    assign status.full_prov    = !est_reg.eknown && boot_ok;
    assign status.empty_prov   = !est_reg.fknown && boot_ok;
    assign status.span_use     = est_reg.span_valid && est_reg.span > 32'(bcse_pkg::MIN_SPAN);
    assign status.div_done     = div_done;
    assign status.out_free     = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, out_reg.eev, out_reg.fev, out_reg.prov, out_reg.known, out_reg.pct};

    `BCSE_ASSERT(a_prov_needs_span, aclk, aresetn, est_reg.span_prov |-> est_reg.span_valid, "provisional flag without span")
    `BCSE_ASSERT(a_span_above_min, aclk, aresetn, est_reg.span_valid |-> est_reg.span > 32'(bcse_pkg::MIN_SPAN), "span at or below minimum")
    `BCSE_ASSERT(a_pct_range, aclk, aresetn, m_valid_reg |-> out_reg.pct <= 14'(bcse_pkg::FULL_SCALE), "percent out of range")

endmodule

@@ rtl/core/bcse_ctrl.sv @@
// controller: sequences capture, curve, update, endpoints, percent and output
module bcse_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  bcse_pkg::dp_status_t status,
    output bcse_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRV,
        ST_CRV_GO,
        ST_CRV_WAIT,
        ST_UPDATE,
        ST_FULL,
        ST_FULL_GO,
        ST_FULL_WAIT,
        ST_EMPTY,
        ST_EMPTY_GO,
        ST_EMPTY_WAIT,
        ST_PCT,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   crv_done_reg, crv_done_next, upd_done_reg, upd_done_next;

    always_comb begin
        state_next     = state_reg;
        crv_done_next  = crv_done_reg;
        upd_done_next  = upd_done_reg;
        cmd.code       = bcse_pkg::CMD_NONE;
        cmd.div_start  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.code      = bcse_pkg::CMD_CAPTURE;
                    crv_done_next = 1'b0;
                    upd_done_next = 1'b0;
                    // first sample needs the curve before the update
                    state_next    = status.counter_seen ? ST_UPDATE : ST_CRV;
                end
            end
            ST_CRV: begin
                if (status.crv_div) begin
                    cmd.code   = bcse_pkg::CMD_CRV_LOAD;
                    state_next = ST_CRV_GO;
                end else begin
                    cmd.code      = bcse_pkg::CMD_CRV_DIRECT;
                    crv_done_next = 1'b1;
                    state_next    = upd_done_reg ? ST_PCT : ST_UPDATE;
                end
            end
            ST_CRV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_CRV_WAIT;
            end
            ST_CRV_WAIT: begin
                if (status.div_done) begin
                    cmd.code      = bcse_pkg::CMD_CRV_FIN;
                    crv_done_next = 1'b1;
                    state_next    = upd_done_reg ? ST_PCT : ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.code      = bcse_pkg::CMD_UPDATE;
                upd_done_next = 1'b1;
                state_next    = ST_FULL;
            end
            ST_FULL: begin
                if (status.full_ev) begin
                    cmd.code   = bcse_pkg::CMD_SET_FULL;
                    state_next = status.full_prov ? ST_FULL_GO : ST_EMPTY;
                end else begin
                    state_next = ST_EMPTY;
                end
            end
            ST_FULL_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_FULL_WAIT;
            end
            ST_FULL_WAIT: begin
                if (status.div_done) begin
                    cmd.code   = bcse_pkg::CMD_FULL_FIN;
                    state_next = ST_EMPTY;
                end
            end
            ST_EMPTY: begin
                if (status.empty_ev) begin
                    cmd.code   = bcse_pkg::CMD_SET_EMPTY;
                    state_next = status.empty_prov ? ST_EMPTY_GO : ST_PCT;
                end else begin
                    state_next = ST_PCT;
                end
            end
            ST_EMPTY_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_EMPTY_WAIT;
            end
            ST_EMPTY_WAIT: begin
                if (status.div_done) begin
                    cmd.code   = bcse_pkg::CMD_EMPTY_FIN;
                    state_next = ST_PCT;
                end
            end
            ST_PCT: begin
                if (status.span_use) begin
                    cmd.code   = bcse_pkg::CMD_PCT_LOAD;
                    state_next = ST_PCT_GO;
                end else if (crv_done_reg) begin
                    cmd.code   = bcse_pkg::CMD_PCT_CURVE;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CRV;
                end
            end
            ST_PCT_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_PCT_WAIT;
            end
            ST_PCT_WAIT: begin
                if (status.div_done) begin
                    cmd.code   = bcse_pkg::CMD_PCT_FIN;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.code   = bcse_pkg::CMD_OUT_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            crv_done_reg <= 1'b0;
            upd_done_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            crv_done_reg <= crv_done_next;
            upd_done_reg <= upd_done_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

@@ rtl/core/battery_charge_state_estimator.sv @@
// top level of the battery charge state estimator
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata, 128 bits, one pack sample
//  m_       | out | m_tvalid/m_tready  | m_tdata, 24 bits, one estimate
//  cfg_     | in  | cfg_wr_en          | cfg_index, cfg_data, 64 bits
//
// a sample with a learned span setting the percent runs capture, update, two
// endpoint checks, divider load, one bit-serial divider pass and the output step.
// without a span the curve sets it, with a divider pass if a segment is interpolated.
// the first sample runs the curve before the update; an endpoint marked while the other
// end is unknown adds a divider pass when the boot percent is in range; m_tready stalls add.
// reset is synchronous; no clearing pass, a sample can be taken right after it.
// a finished estimate waits in the output register while the next sample is taken.
module battery_charge_state_estimator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // coulomb_count[31:0], current_ma[47:32], average_cell_mv[62:48],
    // maximum_cell_mv[77:63], minimum_cell_mv[92:78], overvoltage_flag[93],
    // undervoltage_flag[94], time_ms[126:95], zero[127]
    input  logic [bcse_pkg::IN_W-1:0]           s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // charge_percent[13:0], span_known[14], span_is_provisional[15],
    // full_event[16], empty_event[17], zero[23:18]
    output logic [bcse_pkg::OUT_W-1:0]          m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [bcse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcse_pkg::CFG_W-1:0]          cfg_data
);

    bcse_pkg::dp_cmd_t    cmd;
    bcse_pkg::dp_status_t status;

    bcse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bcse_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ test/bcse_checker.sv @@
// checker for the charge state estimator: watches the sample, result and config channels, predicts, compares
`timescale 1ns / 1ps

module bcse_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [bcse_pkg::IN_W-1:0]       s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bcse_pkg::OUT_W-1:0]      m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [bcse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcse_pkg::CFG_W-1:0]      cfg_data,
    output int                              fail_count,
    output int                              pending
);

    // register copies
    logic [14:0] low_mv, full_mv;
    logic [9:0]  margin_mv;
    logic [31:0] hold_ms;
    logic [30:0] max_step;
    logic [63:0] crv_mv_lo, crv_mv_hi, crv_pct;

    // estimator state
    longint      charge, last_count, full_anchor, empty_anchor, boot_charge, boot_frac;
    logic [31:0] full_hold, empty_hold, span;
    bit          count_seen, chg_seen, dis_seen, full_lat, empty_lat;
    bit          full_known, empty_known, span_ok, span_prov;

    logic [17:0] soc_queue[$];

    assign pending = soc_queue.size();

    function automatic longint clamp_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [31:0] clamp_u32(longint v);
        if (v > 64'sd4294967295) return 32'hFFFF_FFFF;
        if (v < 0) return 32'd0;
        return v[31:0];
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint curve_mv(int i);
        logic [63:0] r;
        r = (i < 4) ? crv_mv_lo : crv_mv_hi;
        return longint'((r >> (16 * (i % 4))) & 64'hFFFF);
    endfunction

    function automatic longint curve_pc(int i);
        longint p;
        p = longint'((crv_pct >> (8 * i)) & 64'hFF);
        return (p > bcse_pkg::PCT_MAX ? bcse_pkg::PCT_MAX : p) * 100;
    endfunction

    function automatic longint curve_soc(longint mv);
        longint b, lo, hi;
        b = mv;
        if (b > longint'(full_mv)) b = full_mv;
        if (b < longint'(low_mv)) b = low_mv;
        if (b <= curve_mv(0)) return curve_pc(0);
        if (b >= curve_mv(bcse_pkg::CURVE_POINTS - 1))
            return curve_pc(bcse_pkg::CURVE_POINTS - 1);
        for (int i = 0; i + 1 < bcse_pkg::CURVE_POINTS; i++) begin
            lo = curve_mv(i);
            hi = curve_mv(i + 1);
            if (b >= lo && b <= hi) begin
                if (hi == lo) return curve_pc(i);
                return curve_pc(i) + round_div((b - lo) * (curve_pc(i + 1) - curve_pc(i)),
                                               hi - lo);
            end
        end
        return bcse_pkg::CRV_FALLBACK;
    endfunction

    function automatic void learn_span();
        longint measured;
        measured = full_anchor - empty_anchor;
        if (measured <= bcse_pkg::MIN_SPAN) return;
        span = clamp_u32(measured);
        span_ok = 1;
        span_prov = 0;
    endfunction

    function automatic void anchor_full();
        longint s;
        full_known = 1;
        full_anchor = charge;
        if (empty_known) learn_span();
        else if (boot_frac >= bcse_pkg::BOOT_LO && boot_frac <= bcse_pkg::BOOT_HI) begin
            s = round_div((full_anchor - boot_charge) * bcse_pkg::FULL_SCALE,
                          bcse_pkg::FULL_SCALE - boot_frac);
            if (s > bcse_pkg::MIN_SPAN) begin
                span = clamp_u32(s);
                empty_anchor = clamp_s32(full_anchor - longint'(span));
                span_ok = 1;
                span_prov = 1;
            end
        end
        full_hold = 0;
    endfunction

    function automatic void anchor_empty();
        longint s;
        empty_known = 1;
        empty_anchor = charge;
        if (full_known) learn_span();
        else if (boot_frac >= bcse_pkg::BOOT_LO && boot_frac <= bcse_pkg::BOOT_HI) begin
            s = round_div((boot_charge - empty_anchor) * bcse_pkg::FULL_SCALE, boot_frac);
            if (s > bcse_pkg::MIN_SPAN) begin
                span = clamp_u32(s);
                full_anchor = clamp_s32(empty_anchor + longint'(span));
                span_ok = 1;
                span_prov = 1;
            end
        end
        empty_hold = 0;
    endfunction

    function automatic logic [17:0] estimate_soc(logic [126:0] d);
        longint count, cur, avg, vmax, vmin, delta, mag, soc;
        logic [31:0] now;
        bit ov, uv, full_v, empty_v, full_hit, empty_hit, full_ev, empty_ev;
        count = longint'(signed'(d[31:0]));
        cur   = longint'(signed'(d[47:32]));
        avg   = d[62:48];
        vmax  = d[77:63];
        vmin  = d[92:78];
        ov    = d[93];
        uv    = d[94];
        now   = d[126:95];
        full_ev = 0;
        empty_ev = 0;
        if (!count_seen) begin
            boot_frac = curve_soc(avg);
            boot_charge = charge;
        end else begin
            delta = count - last_count;
            mag = delta < 0 ? -delta : delta;
            if (mag < longint'(max_step)) charge = clamp_s32(charge + delta);
        end
        last_count = count;
        count_seen = 1;
        if (cur < -bcse_pkg::DIR_THRESH) chg_seen = 1;
        else if (cur > bcse_pkg::DIR_THRESH) dis_seen = 1;
        full_v  = vmax >= longint'(full_mv) - longint'(margin_mv);
        empty_v = vmin <= longint'(low_mv) + longint'(margin_mv);
        if (full_v) begin
            if (full_hold == 0) full_hold = now;
        end else full_hold = 0;
        if (empty_v) begin
            if (empty_hold == 0) empty_hold = now;
        end else empty_hold = 0;
        mag = cur < 0 ? -cur : cur;
        full_hit = ov || (full_v && chg_seen && mag < bcse_pkg::DIR_THRESH && full_hold != 0 &&
                          32'(now - full_hold) >= hold_ms);
        empty_hit = uv || (empty_v && dis_seen && empty_hold != 0 &&
                           32'(now - empty_hold) >= hold_ms);
        if (!full_hit) full_lat = 0;
        else if (!full_lat) begin
            anchor_full();
            full_lat = 1;
            full_ev = 1;
        end
        if (!empty_hit) empty_lat = 0;
        else if (!empty_lat) begin
            anchor_empty();
            empty_lat = 1;
            empty_ev = 1;
        end
        if (span_ok && span > bcse_pkg::MIN_SPAN)
            soc = round_div((charge - empty_anchor) * bcse_pkg::FULL_SCALE, longint'(span));
        else
            soc = curve_soc(avg);
        if (soc < 0) soc = 0;
        if (soc > bcse_pkg::FULL_SCALE) soc = bcse_pkg::FULL_SCALE;
        return {empty_ev, full_ev, span_prov, span_ok, 14'(soc)};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic [17:0] want;
        if (!aresetn) begin
            low_mv <= 3000; full_mv <= 4200; margin_mv <= 20;
            hold_ms <= 60000; max_step <= 100000;
            crv_mv_lo <= 0; crv_mv_hi <= 0; crv_pct <= 0;
            charge = 0; last_count = 0; full_anchor = 0; empty_anchor = 0;
            boot_charge = 0; boot_frac = 0; full_hold = 0; empty_hold = 0; span = 0;
            count_seen = 0; chg_seen = 0; dis_seen = 0; full_lat = 0; empty_lat = 0;
            full_known = 0; empty_known = 0; span_ok = 0; span_prov = 0;
            fail_count = 0;
            soc_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                case (bcse_pkg::cfg_reg_t'(cfg_index))
                    bcse_pkg::REG_EMPTY_MV:   low_mv    <= cfg_data[14:0];
                    bcse_pkg::REG_FULL_MV:    full_mv   <= cfg_data[14:0];
                    bcse_pkg::REG_MARGIN_MV:  margin_mv <= cfg_data[9:0];
                    bcse_pkg::REG_HOLD_MS:    hold_ms   <= cfg_data[31:0];
                    bcse_pkg::REG_MAX_STEP:   max_step  <= cfg_data[30:0];
                    bcse_pkg::REG_CURVE_MV_L: crv_mv_lo <= cfg_data;
                    bcse_pkg::REG_CURVE_MV_H: crv_mv_hi <= cfg_data;
                    bcse_pkg::REG_CURVE_PCT:  crv_pct   <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) soc_queue.push_back(estimate_soc(s_tdata[126:0]));
            if (m_tvalid && m_tready) begin
                if (soc_queue.size() == 0) begin
                    $display("unexpected word %h at %0t", m_tdata, $realtime);
                    fail_count++;
                end else begin
                    want = soc_queue.pop_front();
                    if (m_tdata[13:0] != want[13:0])
                        report_mismatch("charge_percent", m_tdata[13:0], want[13:0]);
                    if (m_tdata[14] != want[14])
                        report_mismatch("span_known", m_tdata[14], want[14]);
                    if (m_tdata[15] != want[15])
                        report_mismatch("span_is_provisional", m_tdata[15], want[15]);
                    if (m_tdata[16] != want[16])
                        report_mismatch("full_event", m_tdata[16], want[16]);
                    if (m_tdata[17] != want[17])
                        report_mismatch("empty_event", m_tdata[17], want[17]);
                end
            end
        end
    end

endmodule

@@ test/tb.sv @@
// testbench top for the charge state estimator: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bcse_pkg::IN_W-1:0]       s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [bcse_pkg::OUT_W-1:0]      m_tdata;
    logic                            cfg_wr_en;
    logic [bcse_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bcse_pkg::CFG_W-1:0]      cfg_data;
    int                              fail_count;
    int                              pending;

    int          send_idle_pct, recv_idle_pct;
    longint      cycles = 0;
    // stimulus-side copies, only to aim voltages at the endpoints
    int          full_aim, empty_aim, margin_aim;
    logic [31:0] clock_ms;
    logic [31:0] count_now;

    battery_charge_state_estimator dut (.*);

    bcse_checker chk (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(bcse_pkg::cfg_reg_t idx, logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic send_sample(int cc, int cur, int avg, int vmax, int vmin,
                               bit ov, bit uv, logic [31:0] t);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, t, uv, ov, vmin[14:0], vmax[14:0], avg[14:0], cur[15:0], cc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic int clip_mv(int v);
        return v < 0 ? 0 : (v > 32767 ? 32767 : v);
    endfunction

    task automatic load_curve(bit ascending);
        logic [63:0] lo, hi, pc;
        int mv, p;
        mv = $urandom_range(2800, 3300);
        p = 0;
        for (int i = 0; i < 8; i++) begin
            if (ascending) begin
                mv = mv + $urandom_range(0, 200);
                p = p + $urandom_range(0, 20);
            end else begin
                mv = $urandom_range(0, 65535);
                p = $urandom_range(0, 255);
            end
            if (i < 4) lo[16*i +: 16] = mv[15:0];
            else hi[16*(i-4) +: 16] = mv[15:0];
            pc[8*i +: 8] = p[7:0];
        end
        write_reg(bcse_pkg::REG_CURVE_MV_L, lo);
        write_reg(bcse_pkg::REG_CURVE_MV_H, hi);
        write_reg(bcse_pkg::REG_CURVE_PCT, pc);
    endtask

    task automatic setup_phase(int ph);
        logic [63:0] e, f, m, h, s;
        case (ph)
            1: begin e = 0; f = 32767; m = 1023; h = 0; s = 64'h7FFF_FFFF; end
            2: begin e = 32767; f = 0; m = 0; h = 64'hFFFF_FFFF; s = 0; end
            default: begin
                e = $urandom_range(2900, 3200);
                f = $urandom_range(4000, 4300);
                m = $urandom_range(0, 60);
                h = $urandom_range(0, 20000);
                s = $urandom_range(500, 200000);
            end
        endcase
        full_aim = f;
        empty_aim = e;
        margin_aim = m;
        write_reg(bcse_pkg::REG_EMPTY_MV, e);
        write_reg(bcse_pkg::REG_FULL_MV, f);
        write_reg(bcse_pkg::REG_MARGIN_MV, m);
        write_reg(bcse_pkg::REG_HOLD_MS, h);
        write_reg(bcse_pkg::REG_MAX_STEP, s);
        if (ph == 1) begin
            write_reg(bcse_pkg::REG_CURVE_MV_L, '1);
            write_reg(bcse_pkg::REG_CURVE_MV_H, '1);
            write_reg(bcse_pkg::REG_CURVE_PCT, '1);
        end else load_curve(ph != 2 && $urandom_range(9) != 0);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_sample();
        int kind, cur, vmax, vmin, avg;
        bit ov, uv;
        kind = $urandom_range(0, 19);
        ov = ($urandom_range(99) < 3);
        uv = ($urandom_range(99) < 3);
        clock_ms = clock_ms + $urandom_range(1, 8000);
        count_now = count_now + $urandom_range(0, 4000) - 2000;
        avg = clip_mv($urandom_range(empty_aim, full_aim > empty_aim ? full_aim : empty_aim));
        vmax = clip_mv(avg + $urandom_range(0, 50));
        vmin = clip_mv(avg - $urandom_range(0, 50));
        if (kind < 6) begin
            // charging up to the full band
            cur = -$urandom_range(11, 3000);
            vmax = clip_mv(full_aim - margin_aim + $urandom_range(0, 30) - 5);
        end else if (kind < 9) begin
            // resting at full
            cur = $urandom_range(0, 18) - 9;
            vmax = clip_mv(full_aim - margin_aim + $urandom_range(0, 30) - 3);
        end else if (kind < 15) begin
            // discharging into the empty band
            cur = $urandom_range(11, 3000);
            vmin = clip_mv(empty_aim + margin_aim - $urandom_range(0, 30) + 3);
        end else if (kind < 17) begin
            cur = $urandom_range(0, 65535) - 32768;
        end else if (kind < 18) begin
            cur = $urandom_range(0, 65535) - 32768;
            count_now = $urandom();
        end else begin
            cur = $urandom_range(0, 65535) - 32768;
            avg = $urandom_range(0, 32767);
            vmax = $urandom_range(0, 32767);
            vmin = $urandom_range(0, 32767);
            ov = $urandom_range(1);
            uv = $urandom_range(1);
            clock_ms = $urandom();
        end
        send_sample(count_now, cur, avg, vmax, vmin, ov, uv, clock_ms);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 23;
        recv_idle_pct = 63;
        clock_ms = 0;
        count_now = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        setup_phase(0);

        // directed: boot at time zero, field extremes, flags, implausible jump
        send_sample(0, 0, 3700, 3710, 3690, 0, 0, 32'd0);
        send_sample(32'h7FFF_FFFF, -32768, 32767, 32767, 0, 0, 0, 32'd0);
        send_sample(32'h8000_0000, 32767, 0, 0, 32767, 0, 0, 32'hFFFF_FFFF);
        send_sample(-5, -500, 4150, 4250, 4100, 0, 0, 32'd100);
        send_sample(-5, 0, 4150, 4250, 4100, 0, 0, 32'd90000);
        send_sample(-5, 0, 4150, 4250, 4100, 0, 0, 32'd95000);
        send_sample(500, 300, 3300, 3400, 2950, 0, 0, 32'd100000);
        send_sample(900, 300, 3050, 3100, 2900, 0, 0, 32'd200000);
        send_sample(900, 0, 3500, 3600, 3400, 1, 0, 32'd210000);
        send_sample(900, 0, 3500, 3600, 3400, 1, 1, 32'd220000);
        send_sample(900, 0, 3500, 3600, 3400, 0, 1, 32'd230000);
        send_sample(-2000, 11, 3500, 3600, 3400, 0, 0, 32'hFFFF_FFF0);
        send_sample(-2000, -11, 3500, 3600, 3400, 0, 0, 32'd5);
        send_sample(-2000, 10, 3500, 3600, 3400, 0, 0, 32'd6);
        send_sample(-2000, -10, 3500, 3600, 3400, 0, 0, 32'd7);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            setup_phase(ph == 0 ? 3 : ph);
            if (ph < 2) begin
                send_idle_pct = 23;
                recv_idle_pct = 63;
            end else if (ph < 4) begin
                send_idle_pct = 63;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 170; n++) begin
                random_sample();
                // hold off until every estimate is back
                if (n == 85) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (pending != 0) @(posedge aclk);
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ battery_charge_state_estimator.f @@
+incdir+rtl/core
rtl/core/bcse_pkg.sv
rtl/core/bcse_div.sv
rtl/core/bcse_dp.sv
rtl/core/bcse_ctrl.sv
rtl/core/battery_charge_state_estimator.sv
test/bcse_checker.sv
test/tb.sv
